>>> hw/rtl/nvpm_pkg.sv
package nvpm_pkg;
  localparam int PoolCapacity = 1024;
  localparam int AddrW = $clog2(PoolCapacity);
  localparam int CountW = AddrW + 1;
  localparam int ValueW = 31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SWAIT,
    ST_SCHK,
    ST_NBR,
    ST_NWAIT,
    ST_DECIDE,
    ST_SHRD,
    ST_SHWR,
    ST_PUT,
    ST_DONE
  } nvpm_state_t;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [ValueW-1:0] wr_data;
  } nvpm_mem_req_t;
endpackage

>>> hw/rtl/nvpm_store.sv
module nvpm_store
  import nvpm_pkg::*;
(
  input  logic              clk,
  input  nvpm_mem_req_t     req,
  output logic [ValueW-1:0] rd_data
);
  logic [ValueW-1:0] mem [PoolCapacity];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

>>> hw/rtl/nearest_value_pool_matcher.sv
// Nearest-value pool matcher; sorted store in one RAM, one access a cycle.
// Per input beat: a binary search (up to 11 steps: read, wait, compare);
// a match picks a neighbour and shifts down the entries above it (at least
// one shift step); an insert shifts up, then writes; a drop ends there.
// One item at a time: next input beat taken the cycle after the result.
// Sync active-low reset clears count, side, total and control; store kept.
module nearest_value_pool_matcher
  import nvpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[30:0], pad
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [127:0] out_tdata, // partner_value, cost, total_cost, pad
  output logic [1:0]  out_tuser   // matched, dropped
);
  nvpm_state_t st_r, st_nxt;
  nvpm_mem_req_t req;
  logic [ValueW-1:0] rd_data;

  logic [CountW-1:0] count_r, count_nxt;
  logic              side_r, side_nxt;
  logic [63:0]       sum_r, sum_nxt;
  logic              kind_r, kind_nxt;
  logic [ValueW-1:0] val_r, val_nxt;
  logic              upper_r, upper_nxt; // search mode: upper bound on insert
  logic [CountW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CountW-1:0] pos_r, pos_nxt;     // shift cursor / target
  logic [ValueW-1:0] up_r, up_nxt;       // entry at bound (neighbour above)
  logic              matched_r, matched_nxt, dropped_r, dropped_nxt;
  logic [ValueW-1:0] partner_r, partner_nxt, cost_r, cost_nxt;

  logic [CountW-1:0] mid;
  logic              go_right;
  logic [ValueW-1:0] d_up, d_dn;

  nvpm_store u_store (.clk(clk), .req(req), .rd_data(rd_data));

  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign go_right = upper_r ? (rd_data <= val_r) : (rd_data < val_r);
  assign d_up     = up_r - val_r;
  assign d_dn     = val_r - rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      count_r <= '0;
      side_r <= 1'b0;
      sum_r <= '0;
    end else begin
      st_r <= st_nxt;
      count_r <= count_nxt;
      side_r <= side_nxt;
      sum_r <= sum_nxt;
    end
    kind_r <= kind_nxt; val_r <= val_nxt; upper_r <= upper_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; pos_r <= pos_nxt; up_r <= up_nxt;
    matched_r <= matched_nxt; dropped_r <= dropped_nxt;
    partner_r <= partner_nxt; cost_r <= cost_nxt;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          st_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (lo_r == hi_r) begin
          priority if (dropped_r) st_nxt = ST_DONE;
          else if (upper_r) st_nxt = (pos_r == lo_r) ? ST_PUT : ST_SHRD;
          else st_nxt = ST_NBR;
        end else begin
          st_nxt = ST_SWAIT;
        end
      end
      ST_SWAIT: st_nxt = ST_SCHK;
      ST_SCHK:  st_nxt = ST_SRCH;
      ST_NBR:   st_nxt = ST_NWAIT;
      ST_NWAIT: st_nxt = ST_DECIDE;
      ST_DECIDE: st_nxt = ST_SHRD;
      ST_SHRD:  st_nxt = ST_SHWR;
      ST_SHWR: begin
        // remove: last entry moved is the one at the new count - 1
        priority if (!upper_r && pos_r + 1'b1 >= count_r) st_nxt = ST_DONE;
        else if (upper_r && pos_r - 1'b1 == lo_r) st_nxt = ST_PUT;
        else st_nxt = ST_SHRD;
      end
      ST_PUT:  st_nxt = ST_DONE;
      ST_DONE: begin
        if (out_tready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and store requests
  always_comb begin
    count_nxt = count_r; side_nxt = side_r; sum_nxt = sum_r;
    kind_nxt = kind_r; val_nxt = val_r; upper_nxt = upper_r;
    lo_nxt = lo_r; hi_nxt = hi_r; pos_nxt = pos_r; up_nxt = up_r;
    matched_nxt = matched_r; dropped_nxt = dropped_r;
    partner_nxt = partner_r; cost_nxt = cost_r;
    req = '0;
    unique case (st_r)
      ST_IDLE: begin
        kind_nxt = in_tuser;
        val_nxt = in_tdata[ValueW-1:0];
        upper_nxt = !(count_r != '0 && side_r != in_tuser);
        dropped_nxt = upper_nxt && (count_r == CountW'(PoolCapacity));
        matched_nxt = 1'b0; partner_nxt = '0; cost_nxt = '0;
        lo_nxt = '0; hi_nxt = count_r; pos_nxt = count_r;
      end
      ST_SRCH: begin
        if (lo_r != hi_r) begin
          req.rd_en = 1'b1;
          req.rd_addr = mid[AddrW-1:0];
        end else if (!upper_r) begin
          pos_nxt = lo_r;
        end
      end
      ST_SCHK: begin
        if (go_right) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
      end
      ST_NBR: begin
        // fetch entry at bound and below it
        req.rd_en = 1'b1;
        req.rd_addr = (lo_r == count_r) ? AddrW'(lo_r - 1'b1) : lo_r[AddrW-1:0];
      end
      ST_NWAIT: begin
        up_nxt = rd_data;
        req.rd_en = 1'b1;
        req.rd_addr = (lo_r == '0) ? '0 : AddrW'(lo_r - 1'b1);
      end
      ST_DECIDE: begin
        // up_r = entry at bound (or last), rd_data = entry below (or first)
        if (lo_r == '0) begin
          pos_nxt = '0; partner_nxt = up_r;
        end else if (lo_r == count_r || !(d_up < d_dn)) begin
          pos_nxt = lo_r - 1'b1; partner_nxt = rd_data;
        end else begin
          pos_nxt = lo_r; partner_nxt = up_r;
        end
        cost_nxt = (partner_nxt > val_r) ? partner_nxt - val_r : val_r - partner_nxt;
        sum_nxt = sum_r + 64'(cost_nxt);
        matched_nxt = 1'b1;
        count_nxt = count_r - 1'b1;
      end
      ST_SHRD: begin
        req.rd_en = 1'b1;
        if (upper_r) req.rd_addr = AddrW'(pos_r - 1'b1);
        else req.rd_addr = AddrW'(pos_r + 1'b1);
        if (!upper_r && pos_r >= count_r) req.rd_en = 1'b0;
      end
      ST_SHWR: begin
        req.wr_en = !(!upper_r && pos_r >= count_r);
        req.wr_addr = pos_r[AddrW-1:0];
        req.wr_data = rd_data;
        if (upper_r) pos_nxt = pos_r - 1'b1;
        else pos_nxt = pos_r + 1'b1;
      end
      ST_PUT: begin
        req.wr_en = 1'b1;
        req.wr_addr = lo_r[AddrW-1:0];
        req.wr_data = val_r;
        count_nxt = count_r + 1'b1;
        side_nxt = kind_r;
      end
      default: ;
    endcase
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_DONE);
  assign out_tdata  = {2'b0, sum_r, cost_r, partner_r};
  assign out_tuser  = {dropped_r, matched_r};
endmodule

>>> tb/tb.sv
module tb;
  import nvpm_pkg::*;

  typedef struct packed {
    logic              matched;
    logic [ValueW-1:0] partner;
    logic [ValueW-1:0] cost;
    logic [63:0]       total;
    logic              dropped;
  } match_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;   // value[30:0], pad
  logic         in_tuser = 1'b0; // kind
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // partner_value, cost, total_cost, pad
  logic [1:0]   out_tuser;       // matched, dropped

  nearest_value_pool_matcher uut (.*);

  always #6 clk = ~clk;

  // shadow of the sorted pool and running total
  logic [ValueW-1:0] pool_q[$];
  logic              pool_owner;
  logic [63:0]       cost_total;
  match_res_t        pending_q[$];
  int                mismatches = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;

  function automatic match_res_t pair_or_insert(logic kind, logic [ValueW-1:0] v);
    match_res_t r;
    int         i;
    int         pick;
    logic [ValueW-1:0] up;
    logic [ValueW-1:0] down;
    r = '0;
    if (pool_q.size() > 0 && pool_owner != kind) begin
      i = 0;
      while (i < pool_q.size() && pool_q[i] < v) i++;
      if (i == 0) pick = 0;
      else if (i >= pool_q.size()) pick = i - 1;
      else begin
        up = pool_q[i] - v;
        down = v - pool_q[i-1];
        pick = (up < down) ? i : i - 1; // tie goes to the smaller value
      end
      r.matched = 1'b1;
      r.partner = pool_q[pick];
      r.cost = (r.partner > v) ? r.partner - v : v - r.partner;
      cost_total += 64'(r.cost);
      pool_q.delete(pick);
    end else if (pool_q.size() >= PoolCapacity) begin
      r.dropped = 1'b1;
    end else begin
      i = 0;
      while (i < pool_q.size() && pool_q[i] <= v) i++; // after equal values
      pool_q.insert(i, v);
      pool_owner = kind;
    end
    r.total = cost_total;
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(logic kind, logic [ValueW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, v};
    in_tuser <= kind;
    do @(posedge clk); while (!in_tready);
    pending_q.push_back(pair_or_insert(kind, v));
    @(negedge clk);
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    match_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.matched = out_tuser[0];
      got.dropped = out_tuser[1];
      got.partner = out_tdata[30:0];
      got.cost = out_tdata[61:31];
      got.total = out_tdata[125:62];
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  // empty the pool by matching its largest value each time
  task automatic drain_pool();
    while (pool_q.size() > 0) send_item(~pool_owner, pool_q[pool_q.size()-1]);
  endtask

  task automatic test_directed();
    send_item(1'b1, 31'd0);          // empty pool: insert, side 1
    send_item(1'b0, 31'd0);          // equal value, cost 0
    send_item(1'b0, 31'h7FFF_FFFF);
    send_item(1'b1, 31'd0);          // widest distance
    send_item(1'b0, 31'd10);
    send_item(1'b0, 31'd20);
    send_item(1'b1, 31'd15);         // tie: smaller value wins
    send_item(1'b1, 31'd21);
    send_item(1'b0, 31'd5);
    send_item(1'b0, 31'd5);
    send_item(1'b0, 31'd5);          // equal values kept in order
    send_item(1'b1, 31'd5);
    send_item(1'b1, 31'd0);          // below every entry
    send_item(1'b1, 31'h7FFF_FFFF);  // above every entry
    send_item(1'b1, 31'h5555_5555);
    send_item(1'b0, 31'h2AAA_AAAA);
    drain_pool();
  endtask

  // left full at the end; run last
  task automatic test_full_pool();
    drain_pool();
    for (int i = 0; i < PoolCapacity; i++)
      send_item(1'b0, ValueW'((i << 21) | $urandom_range(0, (1 << 21) - 1)));
    repeat (4) send_item(1'b0, ValueW'($urandom));  // pool full: dropped
    send_item(1'b1, 31'h7FFF_FFFF);
    send_item(1'b0, 31'd0);          // refills the one free slot
    send_item(1'b0, 31'd1);          // dropped again
  endtask

  task automatic test_random(int n);
    logic kind;
    logic [ValueW-1:0] v;
    repeat (n) begin
      if (pool_q.size() >= 24 && $urandom_range(9) != 0) kind = ~pool_owner;
      else kind = 1'($urandom_range(1));
      case ($urandom_range(3))
        0: v = ValueW'($urandom);
        1: v = ValueW'($urandom_range(63));
        2: v = (pool_q.size() > 0) ? pool_q[$urandom_range(pool_q.size() - 1)]
                                   : ValueW'($urandom);
        default: v = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
      endcase
      send_item(kind, v);
    end
  endtask

  initial begin
    int guard;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    pool_owner = 1'b0;
    cost_total = '0;
    send_idle_pct = 22; recv_idle_pct = 50;
    test_directed();
    test_random(190);
    send_idle_pct = 50; recv_idle_pct = 22;
    test_random(190);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(190);
    test_full_pool();
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_q.size() > 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (100) @(negedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("FAIL");
    $finish;
  end
endmodule
